>>> hdl/bmp24r_pkg.sv
`timescale 1ns / 1ps

package bmp24r_pkg;

	// fixed field widths
	localparam int ADDR_W  = 26;
	localparam int SIDE_CW = 13;
	localparam int BPP_W   = 3;
	localparam int BYTE_W  = 8;
	localparam int IDX_W   = 2;
	localparam int DEFAULT_MAX_SIDE = 4096;

	// register reset values
	localparam logic [SIDE_CW-1:0] IMAGE_WIDTH_RST  = 13'd1;
	localparam logic [SIDE_CW-1:0] IMAGE_HEIGHT_RST = 13'd1;
	localparam logic [SIDE_CW-1:0] SCREEN_WIDTH_RST = 13'd1;
	localparam logic [BPP_W-1:0]   BPP_RST          = 3'd4;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_IMAGE_WIDTH     = 2'd0,
		REG_IMAGE_HEIGHT    = 2'd1,
		REG_SCREEN_WIDTH    = 2'd2,
		REG_BYTES_PER_PIXEL = 2'd3
	} reg_idx_t;

	// byte position inside a pixel
	typedef enum logic [1:0] {
		PH_BLUE  = 2'd0,
		PH_GREEN = 2'd1,
		PH_RED   = 2'd2
	} phase_t;

	// controller states
	typedef enum logic [1:0] {
		ST_TAKE  = 2'd0,
		ST_MUL   = 2'd1,
		ST_SCALE = 2'd2
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take_byte;
		logic do_mul;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pixel_byte;
	} status_t;

endpackage

>>> hdl/bmp24r_ctrl.sv
`timescale 1ns / 1ps

module bmp24r_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  bmp24r_pkg::status_t status,
	output bmp24r_pkg::cmd_t    cmd
);

	bmp24r_pkg::state_t state_q, state_d;
	logic out_valid_q, out_valid_d;

	// state and output flag registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bmp24r_pkg::ST_TAKE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			bmp24r_pkg::ST_TAKE: begin
				in_stall      = 1'b0;
				cmd.take_byte = in_valid;
				if (in_valid && status.pixel_byte) begin
					state_d = bmp24r_pkg::ST_MUL;
				end
			end
			bmp24r_pkg::ST_MUL: begin
				cmd.do_mul = 1'b1;
				state_d    = bmp24r_pkg::ST_SCALE;
			end
			bmp24r_pkg::ST_SCALE: begin
				// output register free or being drained this cycle
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = bmp24r_pkg::ST_TAKE;
				end
			end
			default: begin
				state_d = bmp24r_pkg::ST_TAKE;
			end
		endcase
	end

	// output valid: set on load, cleared on transfer
	always_comb begin
		out_valid_d = out_valid_q;
		if (cmd.load_out) begin
			out_valid_d = 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> hdl/bmp24r_dp.sv
`timescale 1ns / 1ps

module bmp24r_dp #(
	parameter int MAX_SIDE = bmp24r_pkg::DEFAULT_MAX_SIDE
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bmp24r_pkg::IDX_W-1:0]        cfg_index,
	input  logic [bmp24r_pkg::SIDE_CW-1:0]      cfg_data,
	input  logic [bmp24r_pkg::BYTE_W-1:0]       data_byte,
	input  bmp24r_pkg::cmd_t                    cmd,
	output bmp24r_pkg::status_t                 status,
	output logic [bmp24r_pkg::ADDR_W-1:0]       fb_address,
	output logic [bmp24r_pkg::BYTE_W-1:0]       blue,
	output logic [bmp24r_pkg::BYTE_W-1:0]       green,
	output logic [bmp24r_pkg::BYTE_W-1:0]       red,
	output logic                                last_pixel
);

	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int CNT_W  = $clog2(MAX_SIDE);
	localparam int AW     = bmp24r_pkg::ADDR_W;
	localparam int BW     = bmp24r_pkg::BYTE_W;

	// configuration registers
	logic [bmp24r_pkg::SIDE_CW-1:0] image_width_q, image_height_q, screen_width_q;
	logic [bmp24r_pkg::BPP_W-1:0]   bpp_q;

	// raster state
	logic [CNT_W-1:0]   column_q, row_q;
	bmp24r_pkg::phase_t phase_q;
	logic [BW-1:0]      held_blue_q, held_green_q;
	logic [1:0]         pad_q;

	// pixel pipeline
	logic [AW-1:0]    rowterm_s1;
	logic [CNT_W-1:0] col_s1;
	logic [BW-1:0]    blue_s1, green_s1, red_s1;
	logic             last_s1;
	logic [AW-1:0]    sum_s2;

	// output register
	logic [AW-1:0] fb_address_q;
	logic [BW-1:0] blue_q, green_q, red_q;
	logic          last_q;

	logic [31:0]       w32, h32;
	logic [SIDE_W-1:0] eff_w, eff_h;
	logic [SIDE_W:0]   col_inc, row_inc;
	logic              row_end, img_end;
	logic [AW-1:0]     rowterm;
	logic [AW+bmp24r_pkg::SIDE_CW-1:0] prod;
	logic [AW+bmp24r_pkg::BPP_W-1:0]   scaled;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= bmp24r_pkg::IMAGE_WIDTH_RST;
			image_height_q <= bmp24r_pkg::IMAGE_HEIGHT_RST;
			screen_width_q <= bmp24r_pkg::SCREEN_WIDTH_RST;
			bpp_q          <= bmp24r_pkg::BPP_RST;
		end else if (cfg_we) begin
			case (bmp24r_pkg::reg_idx_t'(cfg_index))
				bmp24r_pkg::REG_IMAGE_WIDTH:     image_width_q  <= cfg_data;
				bmp24r_pkg::REG_IMAGE_HEIGHT:    image_height_q <= cfg_data;
				bmp24r_pkg::REG_SCREEN_WIDTH:    screen_width_q <= cfg_data;
				bmp24r_pkg::REG_BYTES_PER_PIXEL: bpp_q <= cfg_data[bmp24r_pkg::BPP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// effective sides: zero acts as one, clamp to the maximum
	always_comb begin
		w32 = 32'(image_width_q);
		h32 = 32'(image_height_q);
		if (w32 == 32'd0) begin
			w32 = 32'd1;
		end else if (w32 > 32'(MAX_SIDE)) begin
			w32 = 32'(MAX_SIDE);
		end
		if (h32 == 32'd0) begin
			h32 = 32'd1;
		end else if (h32 > 32'(MAX_SIDE)) begin
			h32 = 32'(MAX_SIDE);
		end
		eff_w = w32[SIDE_W-1:0];
		eff_h = h32[SIDE_W-1:0];
	end

	// end of row and image, flipped row term
	assign col_inc = (SIDE_W+1)'(column_q) + 1'b1;
	assign row_inc = (SIDE_W+1)'(row_q) + 1'b1;
	assign row_end = col_inc >= (SIDE_W+1)'(eff_w);
	assign img_end = row_end && (row_inc >= (SIDE_W+1)'(eff_h));
	assign rowterm = AW'(eff_h) - AW'(row_q) - AW'(1);

	assign status.pixel_byte = (pad_q == 2'd0) && (phase_q == bmp24r_pkg::PH_RED);

	// raster counters and held colors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q     <= '0;
			row_q        <= '0;
			phase_q      <= bmp24r_pkg::PH_BLUE;
			held_blue_q  <= '0;
			held_green_q <= '0;
			pad_q        <= '0;
		end else if (cmd.take_byte) begin
			if (pad_q != 2'd0) begin
				pad_q <= pad_q - 2'd1;
			end else begin
				case (phase_q)
					bmp24r_pkg::PH_GREEN: begin
						held_green_q <= data_byte;
						phase_q      <= bmp24r_pkg::PH_RED;
					end
					bmp24r_pkg::PH_RED: begin
						phase_q <= bmp24r_pkg::PH_BLUE;
						if (row_end) begin
							column_q <= '0;
							pad_q    <= eff_w[1:0];
							row_q    <= img_end ? '0 : row_inc[CNT_W-1:0];
						end else begin
							column_q <= col_inc[CNT_W-1:0];
						end
					end
					default: begin
						held_blue_q <= data_byte;
						phase_q     <= bmp24r_pkg::PH_GREEN;
					end
				endcase
			end
		end
	end

	// stage 1: capture the completed pixel
	always_ff @(posedge clk) begin
		if (cmd.take_byte && status.pixel_byte) begin
			rowterm_s1 <= rowterm;
			col_s1     <= column_q;
			blue_s1    <= held_blue_q;
			green_s1   <= held_green_q;
			red_s1     <= data_byte;
			last_s1    <= img_end;
		end
	end

	// stage 2: row offset times stride plus column
	assign prod = rowterm_s1 * screen_width_q;

	always_ff @(posedge clk) begin
		if (cmd.do_mul) begin
			sum_s2 <= prod[AW-1:0] + AW'(col_s1);
		end
	end

	// scale by bytes per pixel into the output register
	assign scaled = sum_s2 * bpp_q;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			fb_address_q <= scaled[AW-1:0];
			blue_q       <= blue_s1;
			green_q      <= green_s1;
			red_q        <= red_s1;
			last_q       <= last_s1;
		end
	end

	assign fb_address = fb_address_q;
	assign blue       = blue_q;
	assign green      = green_q;
	assign red        = red_q;
	assign last_pixel = last_q;

endmodule

>>> hdl/bmp24_raster_to_framebuffer_unit.sv
`timescale 1ns / 1ps
// a pixel write passes stage 1, the sum register and then the output register after
// its red byte transfers; the input stalls from the red byte until the pixel is in
// the output register, which waits while a stalled result is still held there
// reset: arst_n clears the counters and output valid at once and loads the
// registers with width 1, height 1, stride 1 and 4 bytes per pixel
module bmp24_raster_to_framebuffer_unit #(
	parameter int MAX_SIDE = bmp24r_pkg::DEFAULT_MAX_SIDE
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [bmp24r_pkg::BYTE_W-1:0]  data_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [bmp24r_pkg::ADDR_W-1:0]  fb_address,
	output logic [bmp24r_pkg::BYTE_W-1:0]  blue,
	output logic [bmp24r_pkg::BYTE_W-1:0]  green,
	output logic [bmp24r_pkg::BYTE_W-1:0]  red,
	output logic                           last_pixel,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bmp24r_pkg::IDX_W-1:0]   cfg_index,
	input  logic [bmp24r_pkg::SIDE_CW-1:0] cfg_data
);

	bmp24r_pkg::cmd_t    cmd;
	bmp24r_pkg::status_t status;

	// registers always take a write
	assign cfg_ready = 1'b1;

	bmp24r_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	bmp24r_dp #(
		.MAX_SIDE (MAX_SIDE)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.data_byte  (data_byte),
		.cmd        (cmd),
		.status     (status),
		.fb_address (fb_address),
		.blue       (blue),
		.green      (green),
		.red        (red),
		.last_pixel (last_pixel)
	);

endmodule

>>> hdl/bmp24r_checker.sv
`timescale 1ns / 1ps

module bmp24r_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [bmp24r_pkg::ADDR_W-1:0]  fb_address,
	input logic                           last_pixel,
	input logic                           cfg_ready
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(fb_address) && $stable(last_pixel))
		else $error("stalled result changed");

	// a new result only appears while the input side is stalled
	a_rise_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while input was open");

	// no result the cycle right after an input transfer
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result too early after input transfer");

	// register port never blocks
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("register port not ready");

endmodule

bind bmp24_raster_to_framebuffer_unit bmp24r_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.fb_address (fb_address),
	.last_pixel (last_pixel),
	.cfg_ready  (cfg_ready)
);
